// ===== src/rhpf_pkg.sv =====
package rhpf_pkg;

	localparam int COUNT_BITS = 16;
	localparam int NUM_BINS   = 61;
	localparam int BIN_W      = 6;
	localparam int ANGLE_W    = 12;
	localparam int DIFF_W     = ANGLE_W + 2;
	localparam int ROLL_W     = 8;

	typedef logic [COUNT_BITS-1:0]  count_t;
	typedef logic [BIN_W-1:0]       bin_t;
	typedef logic [ANGLE_W-1:0]     angle_t;
	typedef logic signed [DIFF_W-1:0] diff_t;
	typedef logic signed [ROLL_W-1:0] roll_t;

	localparam count_t COUNT_MAX = {COUNT_BITS{1'b1}};

	localparam bin_t PORT_FIRST = 6'd0;
	localparam bin_t PORT_LAST  = 6'd20;
	localparam bin_t STBD_FIRST = 6'd40;
	localparam bin_t STBD_LAST  = 6'd60;

	localparam diff_t HALF_TURN    = 14'sd1800;
	localparam diff_t FULL_TURN    = 14'sd3600;
	localparam diff_t QUARTER_TURN = 14'sd900;
	localparam roll_t ROLL_LIMIT   = 8'sd30;

	// which scan a compare belongs to
	typedef enum logic [1:0] {
		SK_PORT   = 2'd0,
		SK_STBD   = 2'd1,
		SK_CENTRE = 2'd2
	} scan_kind_t;

	typedef struct packed {
		logic       load;
		logic       first;
		logic       last;
		scan_kind_t kind;
	} cmp_op_t;

endpackage

// ===== src/rhpf_ram.sv =====
module rhpf_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 61
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== src/rhpf_cmp.sv =====
module rhpf_cmp (
	input  logic             clk,
	input  rhpf_pkg::cmp_op_t op,
	input  rhpf_pkg::count_t data,
	input  rhpf_pkg::bin_t   idx,
	output rhpf_pkg::bin_t   best_idx
);
	import rhpf_pkg::*;

	count_t             best_q;
	bin_t               idx_q;
	logic [COUNT_BITS:0] diff;
	logic               lt;
	logic               gt;
	logic               take;

	// one subtract gives both orderings
	assign diff = {1'b0, data} - {1'b0, best_q};
	assign lt   = diff[COUNT_BITS];
	assign gt   = !lt && (|diff[COUNT_BITS-1:0]);
	assign take = op.load && (op.first || ((op.kind == SK_CENTRE) ? lt : gt));

	always_ff @(posedge clk) begin
		if (take) begin
			best_q <= data;
			idx_q  <= idx;
		end
	end

	assign best_idx = take ? idx : idx_q;

endmodule

// ===== src/roll_histogram_peak_finder.sv =====
// a rejected beat goes straight to the finish state; an accepted beat first reads and writes
// its bin, then runs the port, starboard and centre scans one after another, since one ram read port
// and one shared compare unit serve all three scans
// throughput: one beat at a time, in_stall stays high until the result is in the output register
// reset: histogram reads as zero through per-bin valid flops, peaks go to 0, 60 and 0
module roll_histogram_peak_finder (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  rhpf_pkg::angle_t    bearing_tenths,
	input  rhpf_pkg::angle_t    wind_tenths,
	input  rhpf_pkg::roll_t     roll_degrees,
	output logic                out_valid,
	input  logic                out_stall,
	output logic                accepted,
	output rhpf_pkg::bin_t      port_bin,
	output rhpf_pkg::bin_t      starboard_bin,
	output rhpf_pkg::bin_t      centre_bin
);
	import rhpf_pkg::*;

	typedef enum logic [8:0] {
		ST_IDLE   = 9'b000000001,
		ST_INC_RD = 9'b000000010,
		ST_INC_WR = 9'b000000100,
		ST_PORT   = 9'b000001000,
		ST_STBD   = 9'b000010000,
		ST_S_DRN  = 9'b000100000,
		ST_CENT   = 9'b001000000,
		ST_C_DRN  = 9'b010000000,
		ST_FIN    = 9'b100000000
	} state_t;

	state_t state_q;
	state_t state_d;

	bin_t    addr_q;
	bin_t    rd_idx_s1;
	cmp_op_t op_d;
	cmp_op_t op_s1;
	logic    ok_q;

	bin_t port_peak_q;
	bin_t starboard_peak_q;
	bin_t centre_point_q;

	logic [NUM_BINS-1:0] bin_vld_q;

	count_t ram_rdata;
	count_t cnt_rd;
	count_t cnt_inc;
	bin_t   cmp_idx;

	diff_t diff_raw;
	diff_t diff_lo;
	diff_t diff_wrap;
	roll_t roll_sum;
	logic  item_ok;

	logic in_fire;
	logic fin_fire;

	logic   out_valid_q;
	logic   accepted_q;
	bin_t   port_bin_q;
	bin_t   starboard_bin_q;
	bin_t   centre_bin_q;

	// heading minus wind, wrapped once each way
	assign diff_raw  = $signed({2'b00, bearing_tenths}) - $signed({2'b00, wind_tenths});
	assign diff_lo   = (diff_raw < -HALF_TURN) ? (diff_raw + FULL_TURN) : diff_raw;
	assign diff_wrap = (diff_lo > HALF_TURN) ? (diff_lo - FULL_TURN) : diff_lo;
	assign roll_sum  = roll_degrees + ROLL_LIMIT;
	assign item_ok   = (diff_wrap < QUARTER_TURN) && (diff_wrap > -QUARTER_TURN)
		&& (roll_degrees >= -ROLL_LIMIT) && (roll_degrees <= ROLL_LIMIT);

	assign in_stall = (state_q != ST_IDLE);
	assign in_fire  = in_valid && !in_stall;
	assign fin_fire = (state_q == ST_FIN) && (!out_valid_q || !out_stall);

	// never-written bins read as zero
	assign cnt_rd  = bin_vld_q[rd_idx_s1] ? ram_rdata : '0;
	assign cnt_inc = (cnt_rd == COUNT_MAX) ? cnt_rd : cnt_rd + count_t'(1);

	rhpf_ram #(
		.WIDTH(COUNT_BITS),
		.DEPTH(NUM_BINS)
	) u_hist (
		.clk  (clk),
		.we   (state_q == ST_INC_WR),
		.waddr(addr_q),
		.wdata(cnt_inc),
		.raddr(addr_q),
		.rdata(ram_rdata)
	);

	rhpf_cmp u_cmp (
		.clk     (clk),
		.op      (op_s1),
		.data    (cnt_rd),
		.idx     (rd_idx_s1),
		.best_idx(cmp_idx)
	);

	always_comb begin
		state_d = state_q;
		op_d    = '{load: 1'b0, first: 1'b0, last: 1'b0, kind: SK_PORT};
		unique case (state_q)
			ST_IDLE: begin
				if (in_fire) begin
					state_d = item_ok ? ST_INC_RD : ST_FIN;
				end
			end
			ST_INC_RD: state_d = ST_INC_WR;
			ST_INC_WR: state_d = ST_PORT;
			ST_PORT: begin
				op_d = '{load: 1'b1, first: (addr_q == PORT_FIRST),
					last: (addr_q == PORT_LAST), kind: SK_PORT};
				if (addr_q == PORT_LAST) begin
					state_d = ST_STBD;
				end
			end
			ST_STBD: begin
				op_d = '{load: 1'b1, first: (addr_q == STBD_LAST),
					last: (addr_q == STBD_FIRST), kind: SK_STBD};
				if (addr_q == STBD_FIRST) begin
					state_d = ST_S_DRN;
				end
			end
			ST_S_DRN: state_d = ST_CENT;
			ST_CENT: begin
				op_d = '{load: 1'b1, first: (addr_q == port_peak_q),
					last: (addr_q == starboard_peak_q), kind: SK_CENTRE};
				if (addr_q == starboard_peak_q) begin
					state_d = ST_C_DRN;
				end
			end
			ST_C_DRN: state_d = ST_FIN;
			ST_FIN: begin
				if (fin_fire) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q          <= ST_IDLE;
			op_s1            <= '{load: 1'b0, first: 1'b0, last: 1'b0, kind: SK_PORT};
			bin_vld_q        <= '0;
			port_peak_q      <= PORT_FIRST;
			starboard_peak_q <= STBD_LAST;
			centre_point_q   <= PORT_FIRST;
			out_valid_q      <= 1'b0;
		end else begin
			state_q <= state_d;
			op_s1   <= op_d;
			if (state_q == ST_INC_WR) begin
				bin_vld_q[addr_q] <= 1'b1;
			end
			// a scan ends in the cycle after its last read
			if (op_s1.load && op_s1.last) begin
				unique case (op_s1.kind)
					SK_PORT:   port_peak_q      <= cmp_idx;
					SK_STBD:   starboard_peak_q <= cmp_idx;
					SK_CENTRE: centre_point_q   <= cmp_idx;
					default: ;
				endcase
			end
			if (fin_fire) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		rd_idx_s1 <= addr_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_fire) begin
					addr_q <= roll_sum[BIN_W-1:0];
					ok_q   <= item_ok;
				end
			end
			ST_INC_WR: addr_q <= PORT_FIRST;
			ST_PORT:   addr_q <= (addr_q == PORT_LAST) ? STBD_LAST : addr_q + bin_t'(1);
			ST_STBD:   addr_q <= addr_q - bin_t'(1);
			ST_S_DRN:  addr_q <= port_peak_q;
			ST_CENT:   addr_q <= addr_q + bin_t'(1);
			default: ;
		endcase
		if (fin_fire) begin
			accepted_q      <= ok_q;
			port_bin_q      <= port_peak_q;
			starboard_bin_q <= starboard_peak_q;
			centre_bin_q    <= centre_point_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign accepted      = accepted_q;
	assign port_bin      = port_bin_q;
	assign starboard_bin = starboard_bin_q;
	assign centre_bin    = centre_bin_q;

	a_port_range: assert property (@(posedge clk) disable iff (!arst_n)
		port_peak_q <= PORT_LAST)
		else $error("port peak outside port bins");

	a_stbd_range: assert property (@(posedge clk) disable iff (!arst_n)
		starboard_peak_q >= STBD_FIRST)
		else $error("starboard peak outside starboard bins");

	a_centre_between: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FIN) |->
		(centre_point_q >= port_peak_q) && (centre_point_q <= starboard_peak_q))
		else $error("centre not between the peaks");

	a_out_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_FIN))
		else $error("result beat raised outside finish state");

endmodule

// ===== test/tb_roll_histogram_peak_finder.sv =====
module tb_roll_histogram_peak_finder;
	import rhpf_pkg::*;

	typedef struct {
		angle_t bearing;
		angle_t wind;
		roll_t  roll;
	} heading_beat_t;

	typedef struct {
		logic accepted;
		bin_t port;
		bin_t stbd;
		bin_t centre;
	} peak_result_t;

	typedef enum logic [1:0] {
		SINK_OPEN,
		SINK_RANDOM,
		SINK_PERIODIC
	} sink_mode_t;

	logic   clk;
	logic   arst_n         = 1'b0;
	logic   in_valid       = 1'b0;
	logic   in_stall;
	angle_t bearing_tenths = '0;
	angle_t wind_tenths    = '0;
	roll_t  roll_degrees   = '0;
	logic   out_valid;
	logic   out_stall      = 1'b0;
	logic   accepted;
	bin_t   port_bin;
	bin_t   starboard_bin;
	bin_t   centre_bin;

	heading_beat_t beats_to_send[$];
	peak_result_t  pending_peaks[$];
	heading_beat_t next_beat;
	peak_result_t  want;

	// predictor state
	count_t hist_counts[NUM_BINS];
	int     held_port;
	int     held_stbd;
	int     held_centre;

	int         burst_left;
	int         gap_left;
	sink_mode_t sink_mode;
	int         mode_left;
	logic [3:0] stall_tick;
	int         beats_taken;
	int         results_seen;
	int         updates_seen;
	int         mismatches;

	roll_histogram_peak_finder i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.bearing_tenths(bearing_tenths),
		.wind_tenths   (wind_tenths),
		.roll_degrees  (roll_degrees),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.accepted      (accepted),
		.port_bin      (port_bin),
		.starboard_bin (starboard_bin),
		.centre_bin    (centre_bin)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic peak_result_t roll_beat(angle_t bearing, angle_t wind, roll_t roll);
		int           turn;
		int           r;
		int           b;
		count_t       top;
		logic         ok;
		peak_result_t res;
		turn = int'(bearing) - int'(wind);
		r = int'(roll);
		// single wrap only, out-of-range angles are taken as they come
		if (turn < -1800)
			turn += 3600;
		if (turn > 1800)
			turn -= 3600;
		ok = (turn > -900) && (turn < 900) && (r >= -30) && (r <= 30);
		if (ok) begin
			b = r + 30;
			if (hist_counts[b] != COUNT_MAX)
				hist_counts[b] = hist_counts[b] + 1'b1;
			held_port = 0;
			top = hist_counts[0];
			for (int i = 0; i <= 20; i++) begin
				if (hist_counts[i] > top) begin
					top = hist_counts[i];
					held_port = i;
				end
			end
			// scan downward so ties keep the outermost bin
			held_stbd = 60;
			top = hist_counts[60];
			for (int i = 60; i >= 40; i--) begin
				if (hist_counts[i] > top) begin
					top = hist_counts[i];
					held_stbd = i;
				end
			end
			held_centre = held_port;
			top = hist_counts[held_port];
			for (int i = held_port; i <= held_stbd; i++) begin
				if (hist_counts[i] < top) begin
					top = hist_counts[i];
					held_centre = i;
				end
			end
		end
		res.accepted = ok;
		res.port = bin_t'(held_port);
		res.stbd = bin_t'(held_stbd);
		res.centre = bin_t'(held_centre);
		return res;
	endfunction

	task automatic queue_beat(int b, int w, int r);
		heading_beat_t hb;
		hb.bearing = angle_t'(b);
		hb.wind = angle_t'(w);
		hb.roll = roll_t'(r);
		beats_to_send.push_back(hb);
	endtask

	task automatic flag_mismatch(string what);
		$display("mismatch at result %0d: %s", results_seen, what);
		mismatches++;
	endtask

	// sender: bursts of beats with random gaps, payload held while stalled
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			bearing_tenths <= '0;
			wind_tenths <= '0;
			roll_degrees <= '0;
			burst_left <= 0;
			gap_left <= 0;
		end else if (!in_valid || !in_stall) begin
			if (in_valid) begin
				pending_peaks.push_back(roll_beat(bearing_tenths, wind_tenths, roll_degrees));
				beats_taken++;
			end
			if (gap_left != 0) begin
				in_valid <= 1'b0;
				gap_left <= gap_left - 1;
			end else if (beats_to_send.size() != 0) begin
				next_beat = beats_to_send.pop_front();
				in_valid <= 1'b1;
				bearing_tenths <= next_beat.bearing;
				wind_tenths <= next_beat.wind;
				roll_degrees <= next_beat.roll;
				if (burst_left <= 1) begin
					burst_left <= $urandom_range(1, 6);
					// long gaps reach across the whole peak search
					if ($urandom_range(0, 3) == 0)
						gap_left <= $urandom_range(0, 140);
					else
						gap_left <= $urandom_range(0, 2);
				end else begin
					burst_left <= burst_left - 1;
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// receiver: checks each result beat and stalls in modes of its own
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			sink_mode <= SINK_OPEN;
			mode_left <= 0;
			stall_tick <= '0;
		end else begin
			if (out_valid && !out_stall) begin
				if (pending_peaks.size() == 0) begin
					flag_mismatch("result beat with no beat outstanding");
				end else begin
					want = pending_peaks.pop_front();
					if (accepted !== want.accepted)
						flag_mismatch($sformatf("accepted %b, want %b", accepted, want.accepted));
					if (port_bin !== want.port)
						flag_mismatch($sformatf("port_bin %0d, want %0d", port_bin, want.port));
					if (starboard_bin !== want.stbd)
						flag_mismatch($sformatf("starboard_bin %0d, want %0d",
							starboard_bin, want.stbd));
					if (centre_bin !== want.centre)
						flag_mismatch($sformatf("centre_bin %0d, want %0d",
							centre_bin, want.centre));
					if (want.accepted)
						updates_seen++;
				end
				results_seen++;
			end
			if (mode_left == 0) begin
				sink_mode <= sink_mode_t'($urandom_range(0, 2));
				mode_left <= $urandom_range(50, 600);
			end else begin
				mode_left <= mode_left - 1;
			end
			stall_tick <= stall_tick + 1'b1;
			case (sink_mode)
				SINK_OPEN: begin
					out_stall <= 1'b0;
				end
				SINK_RANDOM: begin
					out_stall <= ($urandom_range(0, 2) == 0);
				end
				default: begin
					out_stall <= stall_tick[3];
				end
			endcase
		end
	end

	initial begin
		int w;
		int d;
		int h;
		int r;
		int pick;
		for (int i = 0; i < NUM_BINS; i++)
			hist_counts[i] = '0;
		held_port = 0;
		held_stbd = 60;
		held_centre = 0;
		beats_taken = 0;
		results_seen = 0;
		updates_seen = 0;
		mismatches = 0;

		// directed: roll limits, heading window edges, wrap and oversize angles, ties
		queue_beat(0, 0, 0);
		queue_beat(0, 0, -30);
		queue_beat(0, 0, 30);
		queue_beat(0, 0, -31);
		queue_beat(0, 0, 31);
		queue_beat(0, 0, -128);
		queue_beat(0, 0, 127);
		queue_beat(900, 0, 0);
		queue_beat(899, 0, -10);
		queue_beat(0, 900, 10);
		queue_beat(0, 899, 10);
		queue_beat(3599, 0, -30);
		queue_beat(0, 3599, 30);
		queue_beat(1800, 0, 0);
		queue_beat(1801, 0, 0);
		queue_beat(4095, 0, -20);
		queue_beat(0, 4095, 20);
		queue_beat(4095, 4095, -1);
		queue_beat(2700, 0, 5);
		queue_beat(2701, 0, 25);
		queue_beat(0, 2700, 0);
		queue_beat(1234, 1234, -10);
		queue_beat(1234, 1234, 30);
		queue_beat(1234, 1234, 10);

		// random: mostly beats inside the heading window, some at its edges, some noise
		for (int n = 0; n < 500; n++) begin
			pick = $urandom_range(0, 99);
			if (pick < 65) begin
				w = $urandom_range(0, 3599);
				d = int'($urandom_range(0, 1796)) - 898;
				pick = $urandom_range(0, 9);
				if (pick < 4)
					r = int'($urandom_range(0, 20)) - 30;
				else if (pick < 8)
					r = $urandom_range(10, 30);
				else
					r = int'($urandom_range(0, 60)) - 30;
			end else if (pick < 82) begin
				w = $urandom_range(0, 3599);
				d = 899 + int'($urandom_range(0, 2));
				if ($urandom_range(0, 1) == 1)
					d = -d;
				case ($urandom_range(0, 4))
					0: r = -31;
					1: r = -30;
					2: r = 30;
					3: r = 31;
					default: r = int'($urandom_range(0, 60)) - 30;
				endcase
			end else begin
				w = $urandom_range(0, 4095);
				d = 0;
				r = $signed(8'($urandom_range(0, 255)));
			end
			if (pick >= 82 && pick < 100 && d == 0) begin
				h = $urandom_range(0, 4095);
			end else begin
				h = w + d;
				if (h < 0)
					h += 3600;
				if (h >= 3600)
					h -= 3600;
			end
			queue_beat(h, w, r);
		end

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		do
			@(posedge clk);
		while (beats_to_send.size() != 0 || in_valid);
		while (pending_peaks.size() != 0)
			@(posedge clk);
		repeat (120) @(posedge clk);

		$display("%0d beats sent, %0d results checked: %0d updated the histogram, %0d rejected",
			beats_taken, results_seen, updates_seen, results_seen - updates_seen);
		$display("final peaks: port bin %0d, starboard bin %0d, centre bin %0d",
			held_port, held_stbd, held_centre);
		if (mismatches == 0 && pending_peaks.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	initial begin
		#10000000;
		$display("timeout with %0d results outstanding", pending_peaks.size());
		$display("Verification failed");
		$finish;
	end

endmodule

// ===== sim.f =====
src/rhpf_pkg.sv
src/rhpf_ram.sv
src/rhpf_cmp.sv
src/roll_histogram_peak_finder.sv
test/tb_roll_histogram_peak_finder.sv
